FILE: hw/rtl/rtu_rfr_pkg.sv
package rtu_rfr_pkg;

   // Input opcodes
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // Reply modes
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // Frame status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_CRC_ERROR = 1'b1;

   // Register indexes (address bit 2)
   localparam logic REG_STATION_ADDRESS = 1'b0;
   localparam logic REG_REPLY_MODE      = 1'b1;

   // Register reset values
   localparam logic [7:0] STATION_ADDRESS_RESET = 8'd1;
   localparam logic       REPLY_MODE_RESET      = MODE_READ;

   // Frame layout, in byte positions
   localparam logic [8:0] HDR_LEN        = 9'd3;
   localparam logic [8:0] FRAME_OVERHEAD = 9'd5;
   localparam logic [8:0] WRITE_LAST_POS = 9'd7;
   localparam logic [8:0] COUNT_POS      = 9'd2;

   // CRC-16/MODBUS
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef struct packed {
      logic [7:0] station_address;
      logic       reply_mode;
   } cfg_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic       frame_done;
      logic       frame_status;
   } result_type;

   // Fold one byte into the reflected CRC, one bit per step
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] acc;
      acc = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

FILE: hw/rtl/rtu_reply_frame_receiver_unit.sv
// Channel   Handshake              Payload
// req       req_valid / req_stall  req_opcode, req_rx_byte
// rsp       rsp_valid / rsp_stall  rsp_payload_valid, rsp_payload_byte, rsp_payload_index,
//                                  rsp_frame_done, rsp_frame_status
// csr       APB write/read         csr_paddr, csr_pwdata, csr_prdata
//
// One transaction per cycle sustained while the result port does not stall; each accepted
// request passes through the input register, then the result register, to the result port.
// The byte-wide CRC update and frame decode sit between those two registers.
// Synchronous active-high reset clears the frame state and both valid flags.
// A stalled result holds in the result register; the input register takes a
// request while it is empty or its transaction moves on to the result register.
module rtu_reply_frame_receiver_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_opcode,
   input  logic [7:0]                                req_rx_byte,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic                                      rsp_payload_valid,
   output logic [7:0]                                rsp_payload_byte,
   output logic [7:0]                                rsp_payload_index,
   output logic                                      rsp_frame_done,
   output logic                                      rsp_frame_status,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [rtu_rfr_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [rtu_rfr_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [rtu_rfr_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                      csr_pready
);
   import rtu_rfr_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       s1_valid_ff,   s1_valid_in;
   logic       s1_opcode_ff;
   logic [7:0] s1_rx_byte_ff;
   logic       rsp_valid_ff,  rsp_valid_in;
   result_type rsp_data_ff;
   logic       accept;
   logic       advance;

   rtu_rfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rtu_rfr_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .opcode  (s1_opcode_ff),
      .rx_byte (s1_rx_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Move on when the result register is free or being emptied
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input and result payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_opcode_ff  <= req_opcode;
         s1_rx_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_valid = rsp_data_ff.payload_valid;
   assign rsp_payload_byte  = rsp_data_ff.payload_byte;
   assign rsp_payload_index = rsp_data_ff.payload_index;
   assign rsp_frame_done    = rsp_data_ff.frame_done;
   assign rsp_frame_status  = rsp_data_ff.frame_status;

`ifndef NO_ASSERTIONS
   // a byte is never both payload and frame end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload_valid && rsp_frame_done))
      else $error("payload byte also closes a frame");

   // a CRC error is only reported on the closing byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_status) |-> rsp_frame_done)
      else $error("frame status set without frame end");

   // non-payload results carry zero byte and index
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload_valid)
         |-> (rsp_payload_byte == 8'd0 && rsp_payload_index == 8'd0))
      else $error("stale payload fields on non-payload result");

   // a held request with a free output lands in the result register next cycle
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("request failed to reach result register");
`endif

endmodule

FILE: hw/rtl/rtu_rfr_csr.sv
module rtu_rfr_csr (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [rtu_rfr_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [rtu_rfr_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [rtu_rfr_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                      csr_pready,
   output rtu_rfr_pkg::cfg_type                      cfg
);
   import rtu_rfr_pkg::*;

   logic [7:0] station_address_ff;
   logic [7:0] station_address_in;
   logic       reply_mode_ff;
   logic       reply_mode_in;
   logic       write_en;
   logic       reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[2];

   // Decode the write
   always_comb begin
      station_address_in = station_address_ff;
      reply_mode_in      = reply_mode_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_STATION_ADDRESS: station_address_in = csr_pwdata[7:0];
            REG_REPLY_MODE:      reply_mode_in      = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_address_ff <= STATION_ADDRESS_RESET;
         reply_mode_ff      <= REPLY_MODE_RESET;
      end else begin
         station_address_ff <= station_address_in;
         reply_mode_ff      <= reply_mode_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_index)
         REG_STATION_ADDRESS: csr_prdata = {24'h0, station_address_ff};
         REG_REPLY_MODE:      csr_prdata = {31'h0, reply_mode_ff};
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg.station_address = station_address_ff;
   assign cfg.reply_mode      = reply_mode_ff;

endmodule

FILE: hw/rtl/rtu_rfr_frame.sv
module rtu_rfr_frame (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     opcode,
   input  logic [7:0]               rx_byte,
   input  rtu_rfr_pkg::cfg_type     cfg,
   output rtu_rfr_pkg::result_type  result
);
   import rtu_rfr_pkg::*;

   logic        in_frame_ff,        in_frame_in;
   logic [8:0]  byte_position_ff,   byte_position_in;
   logic [7:0]  payload_count_ff,   payload_count_in;
   logic [15:0] running_crc_ff,     running_crc_in;
   logic        first_crc_match_ff, first_crc_match_in;

   logic [7:0]  count_now;
   logic [8:0]  payload_end;
   logic [8:0]  crc_lo_pos;
   logic [8:0]  crc_hi_pos;
   logic        feed;
   logic        done;
   logic [8:0]  index_wide;

   // Count byte is live at its own position
   assign count_now   = (byte_position_ff == COUNT_POS) ? rx_byte : payload_count_ff;
   assign payload_end = {1'b0, count_now} + HDR_LEN;
   assign crc_lo_pos  = payload_end;
   assign crc_hi_pos  = {1'b0, count_now} + (FRAME_OVERHEAD - 9'd1);
   assign feed        = (byte_position_ff < payload_end) || (byte_position_ff < HDR_LEN);
   assign index_wide  = byte_position_ff - HDR_LEN;

   // Work out the result and the next frame state
   always_comb begin
      in_frame_in        = in_frame_ff;
      byte_position_in   = byte_position_ff;
      payload_count_in   = payload_count_ff;
      running_crc_in     = running_crc_ff;
      first_crc_match_in = first_crc_match_ff;
      result             = '0;
      done               = 1'b0;

      if (opcode == OP_RESTART) begin
         // drop any frame in progress
         in_frame_in        = 1'b0;
         byte_position_in   = '0;
         payload_count_in   = '0;
         running_crc_in     = CRC_INIT;
         first_crc_match_in = 1'b0;
      end else if (!in_frame_ff) begin
         // hunt for the station address
         if (rx_byte == cfg.station_address) begin
            in_frame_in        = 1'b1;
            running_crc_in     = crc_feed(CRC_INIT, rx_byte);
            first_crc_match_in = 1'b0;
            payload_count_in   = '0;
            byte_position_in   = 9'd1;
         end
      end else begin
         if (byte_position_ff == COUNT_POS) begin
            payload_count_in = rx_byte;
         end
         if (feed) begin
            running_crc_in = crc_feed(running_crc_ff, rx_byte);
         end

         if (cfg.reply_mode == MODE_READ) begin
            if (byte_position_ff >= HDR_LEN && byte_position_ff < payload_end) begin
               result.payload_valid = 1'b1;
               result.payload_byte  = rx_byte;
               result.payload_index = index_wide[7:0];
            end else if (byte_position_ff >= HDR_LEN && byte_position_ff == crc_lo_pos) begin
               // low CRC byte comes first on the wire
               first_crc_match_in = (rx_byte == running_crc_ff[7:0]);
            end else if (byte_position_ff >= crc_hi_pos) begin
               done                = 1'b1;
               result.frame_status = (first_crc_match_ff && rx_byte == running_crc_ff[15:8])
                                     ? STATUS_OK : STATUS_CRC_ERROR;
            end
         end else begin
            if (byte_position_ff >= WRITE_LAST_POS) begin
               done                = 1'b1;
               result.frame_status = STATUS_OK;
            end
         end

         result.frame_done = done;
         if (done) begin
            in_frame_in        = 1'b0;
            byte_position_in   = '0;
            payload_count_in   = '0;
            running_crc_in     = CRC_INIT;
            first_crc_match_in = 1'b0;
         end else begin
            byte_position_in = byte_position_ff + 9'd1;
         end
      end
   end

   // Hold frame state; advance it as each transaction leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff        <= 1'b0;
         byte_position_ff   <= '0;
         payload_count_ff   <= '0;
         running_crc_ff     <= CRC_INIT;
         first_crc_match_ff <= 1'b0;
      end else if (advance) begin
         in_frame_ff        <= in_frame_in;
         byte_position_ff   <= byte_position_in;
         payload_count_ff   <= payload_count_in;
         running_crc_ff     <= running_crc_in;
         first_crc_match_ff <= first_crc_match_in;
      end
   end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
   import rtu_rfr_pkg::*;

   // Frame layout and CRC-16/MODBUS parameters, in byte positions
   localparam int          PAYLOAD_START = 3;
   localparam int          ECHO_LAST_POS = 7;
   localparam logic [15:0] CRC_SEED      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

   localparam int          QUIET_LIMIT   = 3000;
   localparam int          HOLD_CYCLES   = 300;
   localparam result_type  QUIET         = '0;

   typedef enum logic [2:0] {
      ROW_BYTE, ROW_RESTART, ROW_CRC_LO, ROW_CRC_HI, ROW_BAD_LO, ROW_SET_STATION, ROW_SET_MODE
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   value;
      logic         typed;
      result_type   want;
   } stim_row_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic        req_opcode  = OP_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic        rsp_payload_valid;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_payload_index;
   logic        rsp_frame_done;
   logic        rsp_frame_status;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic        csr_pready;

   // Receiver model state and its copy of the registers
   logic        cfg_mode    = REPLY_MODE_RESET;
   logic [7:0]  cfg_station = STATION_ADDRESS_RESET;
   logic        rx_in_frame = 1'b0;
   logic [8:0]  rx_pos      = '0;
   logic [7:0]  rx_count    = '0;
   logic [15:0] rx_crc      = CRC_SEED;
   logic        rx_lo_ok    = 1'b0;

   result_type   expected_q[$];
   stim_row_type rows[$];
   int          mismatches  = 0;
   int          items_sent  = 0;
   int          burst_left  = 0;
   int          quiet_cycles = 0;
   bit          hold_due    = 1'b0;

   rtu_reply_frame_receiver_unit DUT (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Fold one byte into the reflected CRC, data bit by data bit
   function automatic logic [15:0] crc16_feed(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] c;
      logic        fb;
      c = acc;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ d[k];
         c  = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY_REFL;
         end
      end
      return c;
   endfunction

   function automatic void clear_frame();
      rx_in_frame = 1'b0;
      rx_pos      = '0;
      rx_count    = '0;
      rx_crc      = CRC_SEED;
      rx_lo_ok    = 1'b0;
   endfunction

   // Advance the receiver by one transaction and return what it reports
   function automatic result_type receive_byte(input logic op, input logic [7:0] b);
      result_type r;
      int         p;
      int         n;
      r = '0;
      p = rx_pos;
      n = rx_count;
      if (op == OP_RESTART) begin
         clear_frame();
      end else if (!rx_in_frame) begin
         if (b == cfg_station) begin
            rx_in_frame = 1'b1;
            rx_crc      = crc16_feed(CRC_SEED, b);
            rx_lo_ok    = 1'b0;
            rx_count    = '0;
            rx_pos      = 9'd1;
         end
      end else begin
         // count byte, then CRC over header and payload
         if (p == PAYLOAD_START - 1) begin
            rx_count = b;
            n        = b;
         end
         if (p < n + PAYLOAD_START) begin
            rx_crc = crc16_feed(rx_crc, b);
         end
         if (cfg_mode == MODE_READ) begin
            if (p >= PAYLOAD_START && p < n + PAYLOAD_START) begin
               r.payload_valid = 1'b1;
               r.payload_byte  = b;
               r.payload_index = 8'(p - PAYLOAD_START);
            end else if (p >= PAYLOAD_START && p == n + PAYLOAD_START) begin
               rx_lo_ok = (b == rx_crc[7:0]);
            end else if (p >= n + PAYLOAD_START + 1) begin
               r.frame_done   = 1'b1;
               r.frame_status = (rx_lo_ok && b == rx_crc[15:8]) ? STATUS_OK : STATUS_CRC_ERROR;
            end
         end else if (p >= ECHO_LAST_POS) begin
            r.frame_done   = 1'b1;
            r.frame_status = STATUS_OK;
         end
         if (r.frame_done) begin
            clear_frame();
         end else begin
            rx_pos = 9'(p + 1);
         end
      end
      return r;
   endfunction

   // Offer one transaction in bursts with random gaps; predict on acceptance
   task automatic send_item(input logic op, input logic [7:0] b, input logic typed,
                            input result_type want);
      result_type pred;
      int         gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 3))
            0: gap = 0;
            3: gap = $urandom_range(4, 16);
            default: gap = $urandom_range(1, 3);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      pred = receive_byte(op, b);
      expected_q.push_back(typed ? want : pred);
      items_sent++;
      burst_left--;
   endtask

   // Drop valid and wait until every expected transaction has come back
   task automatic wait_drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_STATION_ADDRESS) begin
         cfg_station = val;
      end else begin
         cfg_mode = val[0];
      end
   endtask

   function automatic void add_row(input row_kind_type kind, input logic [7:0] value,
                                   input logic typed, input result_type want);
      stim_row_type r;
      r.kind  = kind;
      r.value = value;
      r.typed = typed;
      r.want  = want;
      rows.push_back(r);
   endfunction

   function automatic result_type outcome(input logic pv, input logic [7:0] pb,
                                          input logic [7:0] pi, input logic done,
                                          input logic st);
      result_type r;
      r.payload_valid = pv;
      r.payload_byte  = pb;
      r.payload_index = pi;
      r.frame_done    = done;
      r.frame_status  = st;
      return r;
   endfunction

   // One reply frame with random content; noise, restarts, bad CRC and cut-offs now and then
   task automatic random_frame(input logic leave_open);
      logic [7:0]  frame_q[$];
      logic [15:0] crc;
      logic [7:0]  cnt;
      logic [7:0]  b;
      int          sel;
      int          cut;
      sel = $urandom_range(0, 99);
      if (!leave_open && sel < 6) begin
         repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom);
            if (b == cfg_station) begin
               b = ~b;
            end
            send_item(OP_BYTE, b, 1'b0, QUIET);
         end
      end else if (!leave_open && sel < 10) begin
         send_item(OP_RESTART, 8'($urandom), 1'b0, QUIET);
      end else begin
         frame_q.push_back(cfg_station);
         frame_q.push_back(8'($urandom));
         if (cfg_mode == MODE_WRITE) begin
            repeat (6) frame_q.push_back(8'($urandom));
         end else begin
            if ($urandom_range(0, 79) == 0) begin
               cnt = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(9, 254));
            end else begin
               cnt = 8'($urandom_range(0, 8));
            end
            frame_q.push_back(cnt);
            repeat (cnt) frame_q.push_back(8'($urandom));
            crc = CRC_SEED;
            foreach (frame_q[i]) crc = crc16_feed(crc, frame_q[i]);
            if ($urandom_range(0, 6) == 0) begin
               crc = crc ^ 16'(1 << $urandom_range(0, 15));
            end
            frame_q.push_back(crc[7:0]);
            frame_q.push_back(crc[15:8]);
         end
         cut = frame_q.size();
         if (leave_open || $urandom_range(0, 11) == 0) begin
            cut = $urandom_range(1, frame_q.size() - 1);
         end
         for (int i = 0; i < cut; i++) begin
            send_item(OP_BYTE, frame_q[i], 1'b0, QUIET);
         end
         if (!leave_open && cut < frame_q.size() && $urandom_range(0, 1)) begin
            send_item(OP_RESTART, 8'($urandom), 1'b0, QUIET);
         end
      end
   endtask

   // Receiver stall pattern, with one long hold-off on request
   initial begin : receiver
      int seg_left;
      int stall_pct;
      int hold_left;
      bit hold_taken;
      seg_left   = 0;
      stall_pct  = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_due && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(20, 200);
               case ($urandom_range(0, 4))
                  0, 1: stall_pct = 0;
                  2: stall_pct = 25;
                  3: stall_pct = 50;
                  default: stall_pct = 80;
               endcase
            end
            seg_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, got %0h", $time,
                     {rsp_payload_valid, rsp_payload_byte, rsp_payload_index,
                      rsp_frame_done, rsp_frame_status});
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            check_field("payload_valid", want.payload_valid, rsp_payload_valid);
            check_field("payload_byte", want.payload_byte, rsp_payload_byte);
            check_field("payload_index", want.payload_index, rsp_payload_index);
            check_field("frame_done", want.frame_done, rsp_frame_done);
            check_field("frame_status", want.frame_status, rsp_frame_status);
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [7:0] station;
      logic [7:0] b;
      int         phase_end;

      // Directed frames under the reset settings, then write echo and a mode switch
      add_row(ROW_BYTE,    8'h00, 1'b1, QUIET);
      add_row(ROW_BYTE,    8'h01, 1'b1, QUIET);
      add_row(ROW_RESTART, 8'hFF, 1'b1, QUIET);
      add_row(ROW_BYTE,    8'h01, 1'b1, QUIET);
      add_row(ROW_BYTE,    8'h03, 1'b0, QUIET);
      add_row(ROW_BYTE,    8'h02, 1'b0, QUIET);
      add_row(ROW_BYTE,    8'hFF, 1'b1, outcome(1'b1, 8'hFF, 8'd0, 1'b0, STATUS_OK));
      add_row(ROW_BYTE,    8'h00, 1'b1, outcome(1'b1, 8'h00, 8'd1, 1'b0, STATUS_OK));
      add_row(ROW_CRC_LO,  8'h00, 1'b0, QUIET);
      add_row(ROW_CRC_HI,  8'h00, 1'b1, outcome(1'b0, 8'h00, 8'd0, 1'b1, STATUS_OK));
      // station address as function byte, then a corrupted low CRC byte
      add_row(ROW_BYTE,    8'h01, 1'b1, QUIET);
      add_row(ROW_BYTE,    8'h01, 1'b0, QUIET);
      add_row(ROW_BYTE,    8'h00, 1'b0, QUIET);
      add_row(ROW_BAD_LO,  8'h00, 1'b0, QUIET);
      add_row(ROW_CRC_HI,  8'h00, 1'b1, outcome(1'b0, 8'h00, 8'd0, 1'b1, STATUS_CRC_ERROR));
      add_row(ROW_SET_STATION, 8'hFF, 1'b0, QUIET);
      add_row(ROW_SET_MODE,    {7'd0, MODE_WRITE}, 1'b0, QUIET);
      add_row(ROW_BYTE,    8'hFF, 1'b1, QUIET);
      add_row(ROW_BYTE,    8'h10, 1'b0, QUIET);
      add_row(ROW_BYTE,    8'h00, 1'b0, QUIET);
      add_row(ROW_BYTE,    8'h01, 1'b0, QUIET);
      add_row(ROW_BYTE,    8'h00, 1'b0, QUIET);
      add_row(ROW_BYTE,    8'h02, 1'b0, QUIET);
      add_row(ROW_BYTE,    8'hA5, 1'b0, QUIET);
      add_row(ROW_BYTE,    8'h5A, 1'b1, outcome(1'b0, 8'h00, 8'd0, 1'b1, STATUS_OK));
      // open in write mode, finish the frame in read mode
      add_row(ROW_BYTE,    8'hFF, 1'b1, QUIET);
      add_row(ROW_BYTE,    8'h03, 1'b0, QUIET);
      add_row(ROW_BYTE,    8'h00, 1'b0, QUIET);
      add_row(ROW_SET_MODE,    {7'd0, MODE_READ}, 1'b0, QUIET);
      add_row(ROW_CRC_LO,  8'h00, 1'b0, QUIET);
      add_row(ROW_CRC_HI,  8'h00, 1'b1, outcome(1'b0, 8'h00, 8'd0, 1'b1, STATUS_OK));

      // Hold reset, then release it
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table; CRC rows take their byte from the running CRC
      foreach (rows[i]) begin
         case (rows[i].kind)
            ROW_SET_STATION: begin
               wait_drain();
               write_reg(REG_STATION_ADDRESS, rows[i].value);
            end
            ROW_SET_MODE: begin
               wait_drain();
               write_reg(REG_REPLY_MODE, rows[i].value);
            end
            ROW_RESTART: send_item(OP_RESTART, rows[i].value, rows[i].typed, rows[i].want);
            default: begin
               case (rows[i].kind)
                  ROW_CRC_LO: b = rx_crc[7:0];
                  ROW_CRC_HI: b = rx_crc[15:8];
                  ROW_BAD_LO: b = ~rx_crc[7:0];
                  default:    b = rows[i].value;
               endcase
               send_item(OP_BYTE, b, rows[i].typed, rows[i].want);
            end
         endcase
      end

      // Random phases across station address and mode settings
      for (int ph = 0; ph < 12; ph++) begin
         wait_drain();
         case (ph % 4)
            0: station = 8'h00;
            1: station = 8'hFF;
            default: station = 8'($urandom);
         endcase
         write_reg(REG_STATION_ADDRESS, station);
         write_reg(REG_REPLY_MODE, {7'd0, (ph % 3 == 1) ? MODE_WRITE : MODE_READ});
         if (ph == 2) begin
            hold_due = 1'b1;
         end
         phase_end = items_sent + 125;
         while (items_sent < phase_end) random_frame(1'b0);
         // sometimes leave a frame open across the next register change
         if ($urandom_range(0, 1)) begin
            random_frame(1'b1);
         end
      end

      wait_drain();
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
